// ===== rtl/core/pfc_pkg.sv =====
// pfc_pkg: shared constants for the prime factor counter.
// No dependencies; used by pfc_div and prime_factor_counter_unit.
package pfc_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int COUNT_W         = 5;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

// ===== rtl/core/prime_factor_counter_unit.sv =====
// prime_factor_counter_unit: counts prime factors with multiplicity by trial division.
// Depends on pfc_pkg and pfc_div.
//
//   channel  dir  ports                          beat
//   req      in   req_valid req_stall req_value  one value
//   rsp      out  rsp_valid rsp_stall rsp_factor_count  one count
//
// Each trial divisor costs one pass of the bit-serial divider.
// An item's work grows with its trial divisors and factors; a 32-bit prime needs about
// 65535 trial divisors. Values 0 and 1 skip the divider and give a count of zero.
// Reset clears the control state. req_stall is high while an item is in work;
// a finished count waits in the output register while rsp_stall is high.
module prime_factor_counter_unit #(
   parameter int VALUE_WIDTH = pfc_pkg::VALUE_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [VALUE_WIDTH-1:0]       req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [pfc_pkg::COUNT_W-1:0]  rsp_factor_count
);
   import pfc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [VALUE_WIDTH-1:0] n_ff, n_in;
   logic [VALUE_WIDTH-1:0] d_ff, d_in;
   logic [COUNT_W-1:0]     cnt_ff, cnt_in;
   logic                   start_ff, start_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]     rsp_cnt_ff, rsp_cnt_in;
   logic [COUNT_W-1:0]     cnt_inc;
   logic                   accept;
   logic                   rsp_free;
   logic                   div_done;
   logic [VALUE_WIDTH-1:0] div_quo;
   logic [VALUE_WIDTH-1:0] div_rem;

   pfc_div #(
      .W (VALUE_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (start_ff),
      .dividend  (n_ff),
      .divisor   (d_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign cnt_inc   = (cnt_ff == COUNT_MAX) ? cnt_ff : cnt_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      cnt_in       = cnt_ff;
      start_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_cnt_in   = rsp_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               n_in   = req_value;
               d_in   = VALUE_WIDTH'(2);
               cnt_in = '0;
               if (req_value < VALUE_WIDTH'(2)) begin
                  state_in = ST_LOAD;
               end else begin
                  start_in = 1'b1;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (div_quo < d_ff) begin
                  // remaining value is prime
                  cnt_in   = cnt_inc;
                  state_in = ST_LOAD;
               end else if (div_rem == '0) begin
                  n_in     = div_quo;
                  cnt_in   = cnt_inc;
                  start_in = 1'b1;
               end else begin
                  d_in     = d_ff + 1'b1;
                  start_in = 1'b1;
               end
            end
         end
         ST_LOAD: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_cnt_in   = cnt_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff       <= n_in;
      d_ff       <= d_in;
      cnt_ff     <= cnt_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_factor_count = rsp_cnt_ff;

endmodule

// ===== rtl/core/pfc_div.sv =====
// pfc_div: restoring divider, one quotient bit per cycle.
// Depends on pfc_pkg. Raises done when quotient and remainder are ready.
module pfc_div #(
   parameter int W = pfc_pkg::VALUE_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder
);
   import pfc_pkg::*;

   localparam int CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic [W:0]    rem_shift;
   logic [W:0]    diff;

   assign rem_shift = {rem_ff, quo_ff[W-1]};
   assign diff      = rem_shift - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (rem_shift >= {1'b0, dvs_ff}) begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
